@@ design/b64d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 stream decoder package
// Shared constants, types and the alphabet lookup for the decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [1:0] MAX_PADS   = 2'd2;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // Result kind codes as they appear on the output channel.
  localparam logic ITEM_DATA   = 1'b0;
  localparam logic ITEM_STATUS = 1'b1;

  // One queue entry holds every result that a single character causes.
  typedef struct packed {
    logic       has_data;
    logic [7:0] data_byte;
    logic       has_status;
    logic       invalid;
  } entry_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] value;
  } sextet_t;

  // Maps a character to its 6-bit value; hit is low outside the alphabet.
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    r.hit   = 1'b1;
    r.value = '0;
    priority if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.value = 6'd62;
    end else if (c == 8'h2F) begin
      r.value = 6'd63;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/b64d_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 decoder input channel
// Valid/ready channel that carries one text character per transaction.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface
`default_nettype wire

@@ design/b64d_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 decoder output channel
// Valid/ready channel that carries one data byte or one status per transaction.
// ----------------------------------------------------------------------------
interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] data_byte;
  logic       invalid;
  logic       last_result;

  modport source (output valid, output item_kind, output data_byte, output invalid,
                  output last_result, input ready);
  modport sink   (input valid, input item_kind, input data_byte, input invalid,
                  input last_result, output ready);
endinterface
`default_nettype wire

@@ design/b64d_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 decoder front end
// Accepts characters, classifies them and keeps the per-message state.
// ----------------------------------------------------------------------------
module b64d_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire logic [7:0]      text_char_i,
  input  wire logic            end_of_text_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output b64d_pkg::entry_t     entry_o
);

  logic [11:0] acc_q, acc_d;
  logic [2:0]  pend_q, pend_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  pad_q, pad_d;
  logic        err_q, err_d;

  logic                accept;
  b64d_pkg::sextet_t   sx;
  logic [3:0]          pend_sum;
  logic [11:0]         acc_new;
  logic                emit;
  logic [7:0]          byte_val;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign sx      = b64d_pkg::sextet_of(text_char_i);
  assign acc_new = {acc_q[5:0], sx.value};
  assign pend_sum = {1'b0, pend_q} + 4'd6;

  // The byte sits above the bits that remain pending after it.
  always_comb begin
    unique case (pend_sum[2:1])
      2'd1:    byte_val = acc_new[9:2];
      2'd2:    byte_val = acc_new[11:4];
      default: byte_val = acc_new[7:0];
    endcase
  end

  always_comb begin
    acc_d  = acc_q;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    pad_d  = pad_q;
    err_d  = err_q;
    emit   = 1'b0;
    if (text_char_i == b64d_pkg::PAD_CHAR) begin
      if (pad_q != 2'd3) pad_d = pad_q + 2'd1;
    end else if (!sx.hit || pad_q != 2'd0) begin
      err_d = 1'b1;
    end else begin
      acc_d  = acc_new;
      pend_d = pend_sum[2:0];
      cnt_d  = cnt_q + 2'd1;
      emit   = pend_sum[3] && !err_q;
    end
  end

  always_comb begin
    entry_o.has_data   = emit;
    entry_o.data_byte  = byte_val;
    entry_o.has_status = end_of_text_i;
    entry_o.invalid    = err_d || (pad_d > b64d_pkg::MAX_PADS) || (cnt_d == 2'd1);
  end

  assign push_o = accept && (emit || end_of_text_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= '0;
      cnt_q  <= '0;
      pad_q  <= '0;
      err_q  <= 1'b0;
    end else if (accept) begin
      if (end_of_text_i) begin
        acc_q  <= '0;
        pend_q <= '0;
        cnt_q  <= '0;
        pad_q  <= '0;
        err_q  <= 1'b0;
      end else begin
        acc_q  <= acc_d;
        pend_q <= pend_d;
        cnt_q  <= cnt_d;
        pad_q  <= pad_d;
        err_q  <= err_d;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_text_i |=> pend_q == 3'd0 && cnt_q == 2'd0 && pad_q == 2'd0 && !err_q)
    else $error("message state not cleared after last character");

  a_pending_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_q[0] && pend_q != 3'd7)
    else $error("pending bit count out of range");

endmodule
`default_nettype wire

@@ design/b64d_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 decoder result queue
// Short queue of result entries between the front end and the back end.
// ----------------------------------------------------------------------------
module b64d_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire b64d_pkg::entry_t  wdata_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output b64d_pkg::entry_t       rdata_o
);

  localparam int unsigned AW = b64d_pkg::FIFO_AW;
  localparam int unsigned CW = b64d_pkg::FIFO_AW + 1;

  b64d_pkg::entry_t               mem_q [b64d_pkg::FIFO_DEPTH];
  logic [b64d_pkg::FIFO_AW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]                  count_q;

  assign full_o  = count_q == CW'(b64d_pkg::FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + AW'(1);
      if (pop_i)  rptr_q <= rptr_q + AW'(1);
      if (push_i && !pop_i)      count_q <= count_q + CW'(1);
      else if (pop_i && !push_i) count_q <= count_q - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full result queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty result queue");

endmodule
`default_nettype wire

@@ design/b64d_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 decoder back end
// Expands queue entries into data and status results on a registered output.
// ----------------------------------------------------------------------------
module b64d_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              empty_i,
  input  wire b64d_pkg::entry_t  head_i,
  output logic                   pop_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic                   item_kind_o,
  output logic [7:0]             data_byte_o,
  output logic                   invalid_o,
  output logic                   last_result_o
);

  logic       out_valid_q;
  logic       kind_q;
  logic [7:0] byte_q;
  logic       inv_q;
  logic       phase_q, phase_d;
  logic       load;
  logic       sel_status;

  // phase_q is set once the data byte of a two-result entry has been loaded into the output register.
  assign sel_status = !head_i.has_data || phase_q;
  assign load       = !empty_i && (!out_valid_q || ready_i);
  assign pop_o      = load && (sel_status || !head_i.has_status);

  always_comb begin
    phase_d = phase_q;
    if (load && !sel_status && head_i.has_status) phase_d = 1'b1;
    else if (pop_o)                               phase_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load)         out_valid_q <= 1'b1;
      else if (ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (sel_status) begin
        kind_q <= b64d_pkg::ITEM_STATUS;
        byte_q <= '0;
        inv_q  <= head_i.invalid;
      end else begin
        kind_q <= b64d_pkg::ITEM_DATA;
        byte_q <= head_i.data_byte;
        inv_q  <= 1'b0;
      end
    end
  end

  assign valid_o       = out_valid_q;
  assign item_kind_o   = kind_q;
  assign data_byte_o   = byte_q;
  assign invalid_o     = inv_q;
  assign last_result_o = kind_q == b64d_pkg::ITEM_STATUS;

  a_phase_on_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> !empty_i && head_i.has_data && head_i.has_status)
    else $error("status phase without a two-result entry at the head");

  a_data_valid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == b64d_pkg::ITEM_DATA |-> !inv_q)
    else $error("data result carries an invalid flag");

endmodule
`default_nettype wire

@@ design/base64_stream_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes standard-alphabet base64 text, one character per transaction.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload                                        Handshake
//  in_ch    sink       text_char[7:0], end_of_text                    valid/ready
//  out_ch   source     item_kind, data_byte[7:0], invalid, last_result valid/ready
//
//  One character is accepted per cycle; the front end's state update is the
//  per-character path. A character with a byte and a status gives two
//  results, the byte first and then the status. The first result of a
//  character passes the queue write, then the output register, before it is
//  valid. Input stalls only when the four-entry result queue is full.
//  Reset is asynchronous and clears all message state; no clearing pass.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  b64d_in_if.sink   in_ch,
  b64d_out_if.source out_ch
);

  logic             full;
  logic             empty;
  logic             push;
  logic             pop;
  b64d_pkg::entry_t wentry;
  b64d_pkg::entry_t head;

  b64d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_ch.valid),
    .ready_o       (in_ch.ready),
    .text_char_i   (in_ch.text_char),
    .end_of_text_i (in_ch.end_of_text),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (wentry)
  );

  b64d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (head)
  );

  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .valid_o       (out_ch.valid),
    .ready_i       (out_ch.ready),
    .item_kind_o   (out_ch.item_kind),
    .data_byte_o   (out_ch.data_byte),
    .invalid_o     (out_ch.invalid),
    .last_result_o (out_ch.last_result)
  );

endmodule
`default_nettype wire
